[hdl/assert_macros.svh]
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// ccc_pkg
// Types and fixed thresholds for the compressor cycle controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

  localparam int unsigned MIN_SWITCH_GAP       = 3 * 60;
  localparam int unsigned FAILSAFE_ON_LIMIT    = 20 * 60;
  localparam int unsigned FAILSAFE_OFF_LIMIT   = 30 * 60;
  localparam int unsigned LOW_GAS_RUN_TIME     = 10 * 60 * 60;
  localparam int unsigned SUPER_MAX_RUN        = 6 * 60 * 60;
  localparam int unsigned CUT_IN_DEFAULT       = 50 - 10;
  localparam int unsigned LOW_GAS_AMBIENT      = 90;
  localparam int unsigned SUPER_CUT_IN_AMBIENT = 15;
  localparam int unsigned SETPOINT_HIGH_LIMIT  = 50;
  localparam int unsigned SUPER_CUT_OUT_AMB    = 10;
  localparam int unsigned CUT_OUT_OFFSET       = 10;
  localparam logic [7:0]  SETPOINT_RESET       = 8'd40;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [7:0] ambient_temp;
    logic [7:0] evap_temp;
    logic       ambient_fault;
    logic       evap_fault;
    logic       super_request;
  } item_t;

  typedef struct packed {
    logic running;
    logic first_pending;
    logic ambient_seen;
    logic evap_seen;
    logic super_active;
    logic low_gas;
  } flags_t;

  typedef struct packed {
    logic        compressor_drive;
    logic        super_mode;
    logic        low_gas_error;
    logic        beep_pulse;
    logic [15:0] run_seconds;
  } result_t;

endpackage

`default_nettype wire

[hdl/ccc_rule.sv]
// ----------------------------------------------------------------------------
// ccc_rule
// One tick of the controller: timer, low gas check and the four switch rules.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_rule #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire ccc_pkg::item_t    item,
  input  wire logic [7:0]        setpoint,
  input  wire ccc_pkg::flags_t   flags,
  input  wire logic [TIMER_BITS-1:0] elapsed,
  output ccc_pkg::flags_t        flags_next,
  output logic [TIMER_BITS-1:0]  elapsed_next,
  output ccc_pkg::result_t       result
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [TIMER_BITS-1:0] RUN_SAT   = TIMER_BITS'(16'hFFFF);

  logic [TIMER_BITS-1:0] el1;
  logic                  sup;
  logic                  gas_hit;
  logic                  cut_in;
  logic                  cut_out;
  logic                  start_cur;
  logic                  want;
  logic                  start_ok;
  logic                  do_switch;
  logic                  ambient_seen_n;
  logic                  evap_seen_n;
  logic                  super_n;

  always_comb begin
    el1 = (elapsed == TIMER_MAX) ? elapsed : elapsed + TIMER_BITS'(1);
    sup = flags.super_active | item.super_request;

    gas_hit = !(item.ambient_fault && !item.evap_fault) && flags.running &&
              (el1 >= TIMER_BITS'(ccc_pkg::LOW_GAS_RUN_TIME)) &&
              (item.ambient_temp >= 8'(ccc_pkg::LOW_GAS_AMBIENT)) && !flags.low_gas;

    if (setpoint > 8'(ccc_pkg::SETPOINT_HIGH_LIMIT)) begin
      cut_in = item.evap_temp > setpoint;
    end else begin
      cut_in = item.evap_temp > 8'(ccc_pkg::CUT_IN_DEFAULT);
    end

    if (sup) begin
      cut_out = (item.ambient_temp <= 8'(ccc_pkg::SUPER_CUT_OUT_AMB)) ||
                (el1 >= TIMER_BITS'(ccc_pkg::SUPER_MAX_RUN));
    end else begin
      cut_out = ({1'b0, item.ambient_temp} + 9'(ccc_pkg::CUT_OUT_OFFSET)) <=
                {1'b0, setpoint};
    end

    start_cur      = flags.first_pending && !flags.ambient_seen && !flags.evap_seen;
    want           = 1'b0;
    start_ok       = 1'b0;
    ambient_seen_n = flags.ambient_seen;
    evap_seen_n    = flags.evap_seen;
    super_n        = sup;

    priority if (item.ambient_fault && item.evap_fault) begin
      // timed duty cycle
      start_ok = start_cur;
      if (flags.running) begin
        want = el1 > TIMER_BITS'(ccc_pkg::FAILSAFE_ON_LIMIT);
      end else begin
        want = (el1 > TIMER_BITS'(ccc_pkg::FAILSAFE_OFF_LIMIT)) || start_cur;
      end
    end else if (item.ambient_fault) begin
      evap_seen_n = 1'b0;
      if (!flags.running) begin
        ambient_seen_n = 1'b1;
        want           = cut_in;
      end else begin
        start_ok = start_cur;
        want     = (el1 > TIMER_BITS'(ccc_pkg::FAILSAFE_ON_LIMIT)) || !flags.ambient_seen;
      end
    end else if (item.evap_fault) begin
      ambient_seen_n = 1'b0;
      if (flags.running) begin
        evap_seen_n = 1'b1;
        want        = cut_out;
      end else begin
        start_ok = start_cur;
        want     = (el1 > TIMER_BITS'(ccc_pkg::FAILSAFE_ON_LIMIT)) || start_cur ||
                   !flags.evap_seen;
      end
    end else begin
      // normal thermostat with super mode
      ambient_seen_n = 1'b0;
      evap_seen_n    = 1'b0;
      start_ok       = flags.first_pending;
      if (flags.running) begin
        want    = cut_out;
        super_n = sup && !cut_out;
      end else begin
        want = cut_in || (sup && (item.ambient_temp > 8'(ccc_pkg::SUPER_CUT_IN_AMBIENT)));
      end
    end

    do_switch = want && ((el1 >= TIMER_BITS'(ccc_pkg::MIN_SWITCH_GAP)) || start_ok);

    flags_next.running       = do_switch ? !flags.running : flags.running;
    flags_next.first_pending = flags.first_pending && !do_switch;
    flags_next.ambient_seen  = ambient_seen_n;
    flags_next.evap_seen     = evap_seen_n;
    flags_next.super_active  = super_n;
    flags_next.low_gas       = flags.low_gas | gas_hit;
    elapsed_next             = do_switch ? '0 : el1;

    result.compressor_drive = flags_next.running;
    result.super_mode       = super_n;
    result.low_gas_error    = flags_next.low_gas;
    result.beep_pulse       = gas_hit;
    result.run_seconds      = (elapsed_next > RUN_SAT) ? 16'hFFFF : elapsed_next[15:0];
  end

endmodule

`default_nettype wire

[hdl/compressor_cycle_controller_top.sv]
// ----------------------------------------------------------------------------
// compressor_cycle_controller_top
// Compressor on/off controller stepped by one request per one-second tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per tick (temperatures, fault flags, super
//   request). m_* returns one result per request (compressor drive, super
//   mode, low gas error, beep pulse, seconds since the last switch).
//   cfg_we/cfg_wdata write the setpoint; write it only while idle.
// Pipeline and throughput:
//   a request is held in the input register, where the rule logic
//   updates the controller state, and its result is loaded into the output
//   register when the request advances. One request per cycle is sustained
//   while m_tready is high; the input register to output register path is
//   the only stage.
// Reset:
//   rst (synchronous) empties both registers, sets the compressor off, the
//   timer to zero, the start condition pending and the setpoint to 40.
// Stall:
//   while m_tready is low the output register holds; one more request is
//   taken into the input register and then s_tready drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module compressor_cycle_controller_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [7:0]                       cfg_wdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [7:0] ambient_temp, [15:8] evap_temp, [16] super_request, [23:17] zero
  input  wire logic [ccc_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [0] ambient_fault, [1] evap_fault
  input  wire logic [ccc_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] compressor_drive, [1] super_mode, [2] low_gas_error, [3] beep_pulse,
  // [19:4] run_seconds, [23:20] zero
  output logic [ccc_pkg::OUT_TDATA_W-1:0]       m_tdata
);

  logic [7:0]            setpoint;
  logic                  stage_valid;
  ccc_pkg::item_t        stage;
  logic                  advance;
  ccc_pkg::flags_t       flags;
  ccc_pkg::flags_t       flags_next;
  logic [TIMER_BITS-1:0] elapsed;
  logic [TIMER_BITS-1:0] elapsed_next;
  ccc_pkg::result_t      res;
  ccc_pkg::result_t      out_res;

  assign advance  = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= ccc_pkg::SETPOINT_RESET;
    end else if (cfg_we) begin
      setpoint <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage.ambient_temp  <= s_tdata[7:0];
      stage.evap_temp     <= s_tdata[15:8];
      stage.super_request <= s_tdata[16];
      stage.ambient_fault <= s_tuser[0];
      stage.evap_fault    <= s_tuser[1];
    end
  end

  ccc_rule #(
    .TIMER_BITS (TIMER_BITS)
  ) u_rule (
    .item         (stage),
    .setpoint     (setpoint),
    .flags        (flags),
    .elapsed      (elapsed),
    .flags_next   (flags_next),
    .elapsed_next (elapsed_next),
    .result       (res)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.running       <= 1'b0;
      flags.first_pending <= 1'b1;
      flags.ambient_seen  <= 1'b0;
      flags.evap_seen     <= 1'b0;
      flags.super_active  <= 1'b0;
      flags.low_gas       <= 1'b0;
      elapsed             <= '0;
    end else if (advance) begin
      flags   <= flags_next;
      elapsed <= elapsed_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'b0, out_res.run_seconds, out_res.beep_pulse,
                    out_res.low_gas_error, out_res.super_mode,
                    out_res.compressor_drive};

  `ASSERT_CLK(a_stage_holds, stage_valid && !advance |=> stage_valid,
              "stalled request lost from input register")
  `ASSERT_CLK(a_low_gas_sticky, flags.low_gas |=> flags.low_gas,
              "low gas error cleared without reset")
  `ASSERT_CLK(a_beep_sets_error, advance && res.beep_pulse |=> flags.low_gas,
              "beep without latched low gas error")
  `ASSERT_CLK(a_switch_clears_timer,
              advance && (flags_next.running != flags.running) |=> elapsed == '0,
              "compressor switch did not clear the timer")

endmodule

`default_nettype wire

[tb/tb_compressor_cycle_controller_top.sv]
// ----------------------------------------------------------------------------
// tb_compressor_cycle_controller_top
// Checks the compressor cycle controller against a tick-by-tick prediction of
// its state. A short directed run covers the start condition, the switch guard
// and super clearing. Random bursts per fault mode follow at several setpoints.
// Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_compressor_cycle_controller_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int unsigned TIMER_MAX = 65535;

  class compressor_predictor;
    logic [7:0] setpoint;
    bit running, first_pending, ambient_seen, evap_seen, super_on, low_gas;
    int unsigned elapsed;
    ccc_pkg::result_t expected_results[$];
    int unsigned errors;

    function new();
      setpoint = ccc_pkg::SETPOINT_RESET;
      running = 0;
      first_pending = 1;
      ambient_seen = 0;
      evap_seen = 0;
      super_on = 0;
      low_gas = 0;
      elapsed = 0;
      errors = 0;
    endfunction

    function bit start_condition();
      return first_pending && !ambient_seen && !evap_seen;
    endfunction

    function void try_switch(bit on);
      if (on != running &&
          (elapsed >= ccc_pkg::MIN_SWITCH_GAP || start_condition())) begin
        running = on;
        elapsed = 0;
        first_pending = 0;
      end
    endfunction

    function bit cut_in(logic [7:0] evap);
      if (setpoint > ccc_pkg::SETPOINT_HIGH_LIMIT) return evap > setpoint;
      return evap > ccc_pkg::CUT_IN_DEFAULT;
    endfunction

    function bit cut_out(logic [7:0] amb);
      if (super_on)
        return amb <= ccc_pkg::SUPER_CUT_OUT_AMB || elapsed >= ccc_pkg::SUPER_MAX_RUN;
      return int'(amb) + int'(ccc_pkg::CUT_OUT_OFFSET) <= int'(setpoint);
    endfunction

    function void note_tick(ccc_pkg::item_t it);
      ccc_pkg::result_t r;
      bit beep;
      beep = 0;
      if (elapsed < TIMER_MAX) elapsed++;
      if (it.super_request) super_on = 1;
      if (!(it.ambient_fault && !it.evap_fault) && running &&
          elapsed >= ccc_pkg::LOW_GAS_RUN_TIME &&
          it.ambient_temp >= ccc_pkg::LOW_GAS_AMBIENT && !low_gas) begin
        low_gas = 1;
        beep = 1;
      end
      if (it.ambient_fault && it.evap_fault) begin
        if (running && elapsed > ccc_pkg::FAILSAFE_ON_LIMIT) try_switch(0);
        else if (!running &&
                 (elapsed > ccc_pkg::FAILSAFE_OFF_LIMIT || start_condition()))
          try_switch(1);
      end else if (it.ambient_fault) begin
        if (!running) begin
          ambient_seen = 1;
          if (cut_in(it.evap_temp)) try_switch(1);
        end else if (elapsed > ccc_pkg::FAILSAFE_ON_LIMIT || !ambient_seen) begin
          try_switch(0);
        end
        evap_seen = 0;
      end else if (it.evap_fault) begin
        if (running) begin
          evap_seen = 1;
          if (cut_out(it.ambient_temp)) try_switch(0);
        end else if (elapsed > ccc_pkg::FAILSAFE_ON_LIMIT || start_condition() ||
                     !evap_seen) begin
          try_switch(1);
        end
        ambient_seen = 0;
      end else begin
        ambient_seen = 0;
        evap_seen = 0;
        if (running) begin
          // super clears on cut-out even when the guard refuses the switch
          if (cut_out(it.ambient_temp)) begin
            try_switch(0);
            super_on = 0;
          end
        end else if (cut_in(it.evap_temp) ||
                     (super_on && it.ambient_temp > ccc_pkg::SUPER_CUT_IN_AMBIENT)) begin
          try_switch(1);
        end
      end
      r.compressor_drive = running;
      r.super_mode = super_on;
      r.low_gas_error = low_gas;
      r.beep_pulse = beep;
      r.run_seconds = elapsed[15:0];
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(logic [ccc_pkg::OUT_TDATA_W-1:0] data);
      ccc_pkg::result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %h with no request pending", data);
        return;
      end
      want = expected_results.pop_front();
      compare_field("compressor_drive", 16'(want.compressor_drive), 16'(data[0]));
      compare_field("super_mode", 16'(want.super_mode), 16'(data[1]));
      compare_field("low_gas_error", 16'(want.low_gas_error), 16'(data[2]));
      compare_field("beep_pulse", 16'(want.beep_pulse), 16'(data[3]));
      compare_field("run_seconds", want.run_seconds, data[19:4]);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [7:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [ccc_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [ccc_pkg::IN_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [ccc_pkg::OUT_TDATA_W-1:0] m_tdata;

  compressor_predictor predictor;
  bit idle_on = 1;
  int quiet_cycles = 0;

  compressor_cycle_controller_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_compressor_cycle_controller_top failed");
        $finish;
      end
    end
  end

  function automatic ccc_pkg::item_t make_item(logic [7:0] amb, logic [7:0] evap,
                                               bit af, bit ef, bit sr);
    ccc_pkg::item_t it;
    it.ambient_temp = amb;
    it.evap_temp = evap;
    it.ambient_fault = af;
    it.evap_fault = ef;
    it.super_request = sr;
    return it;
  endfunction

  function automatic logic [7:0] pick_temp(int center);
    int v;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    v = center + int'($urandom_range(0, 40)) - 20;
    return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : 8'(v));
  endfunction

  task automatic send_request(ccc_pkg::item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'b0, it.super_request, it.evap_temp, it.ambient_temp};
    s_tuser <= {it.evap_fault, it.ambient_fault};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predictor.note_tick(it);
  endtask

  task automatic write_setpoint(logic [7:0] value);
    s_tvalid <= 0;
    while (predictor.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    predictor.setpoint = value;
  endtask

  // result side
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      predictor.check_result(m_tdata);
    end
  end

  initial begin
    int mode, burst, count, amb_center, evap_center;
    logic [7:0] sp;
    predictor = new();
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed, setpoint still at reset value
    send_request(make_item(8'd0, 8'd0, 1, 0, 0));      // ambient mode drops start condition
    send_request(make_item(8'd0, 8'd0, 0, 0, 0));      // normal rule restores it
    send_request(make_item(8'd0, 8'd0, 1, 1, 0));      // dual fault starts at once
    send_request(make_item(8'd0, 8'd0, 0, 0, 0));      // cut-out refused by guard
    send_request(make_item(8'd5, 8'd0, 0, 0, 1));      // super set and cleared same tick
    send_request(make_item(8'd20, 8'd128, 1, 0, 0));
    send_request(make_item(8'd0, 8'd20, 0, 1, 0));
    send_request(make_item(8'd255, 8'd255, 1, 1, 1));
    send_request(make_item(8'd30, 8'd41, 0, 0, 0));
    send_request(make_item(8'd31, 8'd40, 0, 0, 0));
    send_request(make_item(8'd10, 8'd0, 0, 1, 1));
    send_request(make_item(8'd11, 8'd0, 0, 1, 0));
    send_request(make_item(8'd15, 8'd255, 1, 0, 0));
    send_request(make_item(8'd16, 8'd0, 0, 0, 0));
    send_request(make_item(8'd90, 8'd255, 0, 0, 0));
    send_request(make_item(8'd170, 8'd85, 0, 0, 1));
    send_request(make_item(8'd85, 8'd170, 0, 0, 0));
    send_request(make_item(8'd255, 8'd0, 0, 0, 0));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: sp = 8'd0;
        1: sp = 8'd255;
        2: sp = 8'd51;
        3: sp = 8'd50;
        4: sp = 8'($urandom_range(0, 255));
        default: sp = 8'd40;
      endcase
      write_setpoint(sp);
      count = 0;
      while (count < 240) begin
        mode = $urandom_range(0, 9);
        burst = $urandom_range(1, 60);
        if (burst > 240 - count) burst = 240 - count;
        idle_on = $urandom_range(0, 3) != 0;
        amb_center = ($urandom_range(0, 4) == 0) ? 12 : int'(sp) - 10;
        evap_center = (sp > ccc_pkg::SETPOINT_HIGH_LIMIT) ? int'(sp) :
                      int'(ccc_pkg::CUT_IN_DEFAULT);
        repeat (burst) begin
          send_request(make_item(pick_temp(amb_center), pick_temp(evap_center),
                                 mode inside {5, 6, 9}, mode inside {7, 8, 9},
                                 $urandom_range(0, 29) == 0));
          count++;
        end
      end
    end

    s_tvalid <= 0;
    while (predictor.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (predictor.errors == 0 && predictor.expected_results.size() == 0) begin
      $display("tb_compressor_cycle_controller_top passed");
    end else begin
      $display("tb_compressor_cycle_controller_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
